@@ rtl/core/mhl_pkg.sv @@
// Shared types and constants for the magic header length deframer.
package mhl_pkg;

    localparam logic [31:0] MAGIC_RESET = 32'hFACE_FEED;
    localparam int unsigned HDR_LEN     = 16;
    localparam int unsigned CNT_W       = $clog2(HDR_LEN);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  version;
        logic [7:0]  msg_type;
        logic [15:0] flags;
        logic [31:0] seq_num;
        logic [31:0] body_len;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

@@ rtl/core/mhl_parser.sv @@
// Header collection, magic check and body length tracking, one byte per i_take.
module mhl_parser
    import mhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_res_valid,
    output t_result     o_res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ERROR  = 2'd2
    } t_phase;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_LEN - 1);

    t_phase                       r_phase, n_phase;
    logic [CNT_W-1:0]             r_hdr_cnt, n_hdr_cnt;
    logic [31:0]                  r_body_left, n_body_left;
    logic [31:0]                  r_magic;
    logic [(HDR_LEN-1)*8-1:0]     r_hdr;
    logic                         hdr_shift;
    logic [31:0]                  body_len;
    logic [31:0]                  body_dec;

    assign body_len = {r_hdr[23:0], i_rx_byte};
    assign body_dec = r_body_left - {31'd0, (r_body_left != 32'd0)};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_body_left = r_body_left;
        hdr_shift   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt != CNT_LAST) begin
                    hdr_shift = i_take;
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end else begin
                    n_hdr_cnt   = '0;
                    o_res_valid = i_take;
                    if (r_hdr[119:88] != r_magic) begin
                        n_phase    = PH_ERROR;
                        o_res.kind = KIND_ERROR;
                        o_res.last = 1'b1;
                    end else begin
                        o_res.kind     = KIND_HEADER;
                        o_res.version  = r_hdr[87:80];
                        o_res.msg_type = r_hdr[79:72];
                        o_res.flags    = r_hdr[71:56];
                        o_res.seq_num  = r_hdr[55:24];
                        o_res.body_len = body_len;
                        o_res.last     = (body_len == 32'd0);
                        n_body_left    = body_len;
                        n_phase        = (body_len == 32'd0) ? PH_HEADER : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                o_res_valid     = i_take;
                n_body_left     = body_dec;
                o_res.kind      = KIND_BODY;
                o_res.data_byte = i_rx_byte;
                if (body_dec == 32'd0) begin
                    o_res.last = 1'b1;
                    n_phase    = PH_HEADER;
                    n_hdr_cnt  = '0;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_body_left <= '0;
            r_magic     <= MAGIC_RESET;
        end else begin
            if (i_take) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_body_left <= n_body_left;
            end
            if (i_cfg_we) begin
                r_magic <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_shift) begin
            r_hdr <= {r_hdr[(HDR_LEN-2)*8-1:0], i_rx_byte};
        end
    end

endmodule

@@ rtl/core/mhl_outbuf.sv @@
// Result register with a skid stage that decouples the input side from the receiver.
module mhl_outbuf
    import mhl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    main_free;

    assign main_free = !r_main_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (main_free) begin
            r_main_v <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

endmodule

@@ rtl/core/magic_header_length_deframer.sv @@
// Top level of the magic header length deframer.
//
// The input channel carries one received byte per word (i_valid, o_stall).
// Sixteen header bytes are collected: a 4-byte magic, version, type, 2-byte
// flags, 4-byte sequence number and 4-byte body length, all big-endian.
// The sixteenth byte yields one header word on the output channel, or one
// error word if the magic differs from the configured value; after an error
// every further byte is consumed without output until reset. Each body byte
// then leaves as one word, and the final word of a message carries o_last.
// The magic register is written through i_cfg_valid and i_cfg_data; the
// port is always ready, and a new value applies at the next magic check.
// Each word is registered in the result register, or in the skid stage while
// the receiver stalls; a byte can be accepted every cycle if o_stall is low.
// When the receiver stalls, the result register holds its word and a skid
// stage takes one more; o_stall rises only while that skid stage is full.
// Synchronous reset clears the parser state, restores the reset magic and
// empties both output stages.
module magic_header_length_deframer
    import mhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_version,
    output logic [7:0]  o_msg_type,
    output logic [15:0] o_flags,
    output logic [31:0] o_seq_num,
    output logic [31:0] o_body_len,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    logic    take;
    logic    full;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_stall     = full;
    assign take        = i_valid && !full;
    assign o_cfg_ready = 1'b1;

    mhl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mhl_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_full  (full),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind      = out_res.kind;
    assign o_version   = out_res.version;
    assign o_msg_type  = out_res.msg_type;
    assign o_flags     = out_res.flags;
    assign o_seq_num   = out_res.seq_num;
    assign o_body_len  = out_res.body_len;
    assign o_data_byte = out_res.data_byte;
    assign o_last      = out_res.last;

endmodule

@@ rtl/core/mhl_checker.sv @@
// Port-level assertions for the magic header length deframer and their bind.
module mhl_checker
    import mhl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_version,
    input logic [31:0] o_body_len,
    input logic [7:0]  o_data_byte,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_last) && $stable(o_body_len))
        else $error("Stalled output word changed.");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> o_last && o_body_len == 32'd0)
        else $error("Error word without last or with payload.");

    a_empty_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_HEADER |-> o_last == (o_body_len == 32'd0))
        else $error("Header last flag does not match the body length.");

    a_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == KIND_ERROR |=> !o_valid)
        else $error("Output word after a magic mismatch.");

    a_body_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_BODY |-> o_version == 8'd0 && o_body_len == 32'd0)
        else $error("Body word carries header fields.");

endmodule

bind magic_header_length_deframer mhl_checker u_mhl_checker (.*);

@@ verif/magic_header_length_deframer_check.sv @@
// Checker that predicts the deframer's output words from the observed bytes and compares them.
module magic_header_length_deframer_check
    import mhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_result     i_result,
    output int          o_failures,
    output int          o_pending,
    output int          o_results,
    output int          o_headers
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {IN_HEADER, IN_BODY, IN_ERROR} t_phase;

    t_phase       phase = IN_HEADER;
    logic [4:0]   hdr_count = '0;
    logic [119:0] hdr_shift = '0;
    logic [31:0]  body_left = '0;
    logic [31:0]  magic = MAGIC_RESET;
    t_result      awaited_words[$];
    int           failures = 0;
    int           results = 0;
    int           headers = 0;

    task automatic deframe_byte(input logic [7:0] b);
        logic [127:0] hdr;
        t_result      r;
        r = '0;
        hdr = {hdr_shift, b};
        case (phase)
            IN_HEADER: begin
                if (hdr_count < HDR_LEN - 1) begin
                    hdr_shift = hdr[119:0];
                    hdr_count = hdr_count + 5'd1;
                end else begin
                    hdr_count = '0;
                    r.last = 1'b1;
                    if (hdr[127:96] != magic) begin
                        phase = IN_ERROR;
                        r.kind = KIND_ERROR;
                    end else begin
                        r.kind = KIND_HEADER;
                        r.version = hdr[95:88];
                        r.msg_type = hdr[87:80];
                        r.flags = hdr[79:64];
                        r.seq_num = hdr[63:32];
                        r.body_len = hdr[31:0];
                        r.last = (hdr[31:0] == 32'd0);
                        body_left = hdr[31:0];
                        if (hdr[31:0] == 32'd0) begin
                            phase = IN_HEADER;
                        end else begin
                            phase = IN_BODY;
                        end
                        headers++;
                    end
                    awaited_words.push_back(r);
                end
            end
            IN_BODY: begin
                if (body_left != 32'd0) begin
                    body_left = body_left - 32'd1;
                end
                r.kind = KIND_BODY;
                r.data_byte = b;
                r.last = (body_left == 32'd0);
                if (body_left == 32'd0) begin
                    phase = IN_HEADER;
                    hdr_count = '0;
                end
                awaited_words.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      bad;
        if (!i_rst_n) begin
            phase = IN_HEADER;
            hdr_count = '0;
            body_left = '0;
            magic = MAGIC_RESET;
            awaited_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                magic = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (awaited_words.size() == 0) begin
                    $error("Output word arrived with none expected.");
                    failures++;
                end else begin
                    want = awaited_words.pop_front();
                    bad = field_bad("kind", want.kind, i_result.kind)
                        + field_bad("version", want.version, i_result.version)
                        + field_bad("msg_type", want.msg_type, i_result.msg_type)
                        + field_bad("flags", want.flags, i_result.flags)
                        + field_bad("seq_num", want.seq_num, i_result.seq_num)
                        + field_bad("body_len", want.body_len, i_result.body_len)
                        + field_bad("data_byte", want.data_byte, i_result.data_byte)
                        + field_bad("last", want.last, i_result.last);
                    if (bad != 0) begin
                        failures++;
                    end
                end
            end
        end
        o_failures <= failures;
        o_pending <= awaited_words.size();
        o_results <= results;
        o_headers <= headers;
    end

endmodule

@@ verif/magic_header_length_deframer_test.sv @@
// Testbench top that feeds framed byte streams and magic writes to the deframer.
module magic_header_length_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mhl_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  res_kind;
    logic [7:0]  res_version;
    logic [7:0]  res_msg_type;
    logic [15:0] res_flags;
    logic [31:0] res_seq_num;
    logic [31:0] res_body_len;
    logic [7:0]  res_data_byte;
    logic        res_last;

    int          failures;
    int          pending;
    int          results;
    int          headers;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;
    int          messages = 0;
    int          magic_writes = 0;
    logic [31:0] cur_magic = MAGIC_RESET;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    magic_header_length_deframer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_rx_byte   (rx_byte),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_kind      (res_kind),
        .o_version   (res_version),
        .o_msg_type  (res_msg_type),
        .o_flags     (res_flags),
        .o_seq_num   (res_seq_num),
        .o_body_len  (res_body_len),
        .o_data_byte (res_data_byte),
        .o_last      (res_last)
    );

    magic_header_length_deframer_check i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_rx_byte   (rx_byte),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_result    ({res_kind, res_version, res_msg_type, res_flags, res_seq_num,
                       res_body_len, res_data_byte, res_last}),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_results   (results),
        .o_headers   (headers)
    );

    always @(posedge clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[magic_header_length_deframer] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_message(input logic [31:0] magic, input logic [7:0] version,
                                input logic [7:0] msg_type, input logic [15:0] flags,
                                input logic [31:0] seq_num, input logic [31:0] body_len);
        logic [127:0] hdr;
        hdr = {magic, version, msg_type, flags, seq_num, body_len};
        for (int i = 15; i >= 0; i--) begin
            send_byte(hdr[i*8 +: 8]);
        end
        for (int unsigned i = 0; i < body_len; i++) begin
            send_byte(8'($urandom));
        end
        messages++;
    endtask

    task automatic send_random_message();
        logic [31:0] len;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(64, 13);
        end else begin
            len = $urandom_range(12);
        end
        send_message(cur_magic, 8'($urandom), 8'($urandom), 16'($urandom), $urandom, len);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_magic = value;
        magic_writes++;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 62;
        send_message(cur_magic, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_message(cur_magic, 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 32'd2);
        while (bytes_sent < 200) send_random_message();
        write_magic(32'h0000_0000);
        while (bytes_sent < 380) send_random_message();

        send_idle_pct = 62;
        recv_idle_pct = 7;
        write_magic(32'hFFFF_FFFF);
        while (bytes_sent < 560) send_random_message();
        write_magic($urandom);
        while (bytes_sent < 740) send_random_message();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_magic($urandom);
        hold_asks++;
        send_message(cur_magic, 8'($urandom), 8'($urandom), 16'($urandom), $urandom, 32'd40);
        wait_drained();
        while (bytes_sent < 1060) send_random_message();

        // A corrupted magic ends the stream; the trailing bytes must be swallowed.
        send_message(cur_magic ^ (32'd1 << $urandom_range(31)), 8'($urandom), 8'($urandom),
                     16'($urandom), $urandom, 32'd5);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages with %0d magic writes and three idle mixes.",
                 bytes_sent, messages, magic_writes);
        $display("Checked %0d output words (%0d headers), ending with a magic mismatch.",
                 results, headers);
        if (failures == 0 && pending == 0) begin
            $display("[magic_header_length_deframer] OK");
        end else begin
            $display("[magic_header_length_deframer] ERROR");
        end
        $finish;
    end

endmodule
